@@ rtl/sixbit_squoze_name_codec_top_assert.svh @@
// Assertion macros for the checker file of the name codec.
`ifndef SIXBIT_SQUOZE_NAME_CODEC_TOP_ASSERT_SVH
`define SIXBIT_SQUOZE_NAME_CODEC_TOP_ASSERT_SVH

// Same-cycle implication: when the antecedent holds, the consequent must hold too.
`define SSNC_ASSERT_IMP(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent must hold in the next cycle.
`define SSNC_ASSERT_NXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ssnc_pkg.sv @@
// Types, constants and character tables of the name codec.
`default_nettype none

package ssnc_pkg;

   localparam int NumChars    = 6;
   localparam int CodeWidth   = 6;
   localparam int WordWidth   = 36;
   localparam int SqWidth     = 32;
   localparam int InCharWidth = 8;
   localparam int CharWidth   = 7;
   localparam int Radix       = 40;

   localparam logic [InCharWidth-1:0] SpaceChar = 8'h20;
   localparam logic [InCharWidth-1:0] NulChar   = 8'h00;

   // Operation codes carried in the request.
   typedef enum logic [1:0] {
      OP_SIXBIT_ENC = 2'd0,
      OP_SIXBIT_DEC = 2'd1,
      OP_SQUOZE_ENC = 2'd2,
      OP_SQUOZE_DEC = 2'd3
   } op_type;

   typedef struct packed {
      op_type                 req_type;
      logic [WordWidth-1:0]   in_word;
      logic [InCharWidth-1:0] in_char_0;
      logic [InCharWidth-1:0] in_char_1;
      logic [InCharWidth-1:0] in_char_2;
      logic [InCharWidth-1:0] in_char_3;
      logic [InCharWidth-1:0] in_char_4;
      logic [InCharWidth-1:0] in_char_5;
   } req_item_type;

   typedef struct packed {
      logic [WordWidth-1:0] out_word;
      logic [CharWidth-1:0] out_char_0;
      logic [CharWidth-1:0] out_char_1;
      logic [CharWidth-1:0] out_char_2;
      logic [CharWidth-1:0] out_char_3;
      logic [CharWidth-1:0] out_char_4;
      logic [CharWidth-1:0] out_char_5;
   } rsp_item_type;

   // What one character lane hands to the merge stage.
   typedef struct packed {
      logic [CodeWidth-1:0] six_code;
      logic [CodeWidth-1:0] quo_low;
      logic [SqWidth-1:0]   sq_term;
      logic [CharWidth-1:0] dec_char;
   } lane_out_type;

   // Contents of the lane output register.
   typedef struct packed {
      op_type                        op;
      logic [CodeWidth-1:0]          quo_base;
      lane_out_type [NumChars-1:0]   lanes;
   } stage_type;

   // Integer power, evaluated at elaboration only.
   function automatic longint unsigned int_pow(input int unsigned base,
                                               input int unsigned expo);
      longint unsigned r;
      r = 64'd1;
      for (int k = 0; k < expo; k++) begin
         r = r * base;
      end
      return r;
   endfunction

   // Radix-40 digit of a character; anything unknown maps to the digit of space.
   function automatic logic [CodeWidth-1:0] radix_digit(input logic [InCharWidth-1:0] c);
      logic [CodeWidth-1:0] d;
      priority if (c >= 8'h30 && c <= 8'h39) begin
         d = 6'(c - 8'd47);          // digits 0..9
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         d = 6'(c - 8'd54);          // uppercase letters
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = 6'(c - 8'd86);          // lowercase letters
      end else if (c == 8'h2E) begin
         d = 6'd37;                  // period
      end else if (c == 8'h24) begin
         d = 6'd38;                  // dollar sign
      end else if (c == 8'h25) begin
         d = 6'd39;                  // percent sign
      end else begin
         d = 6'd0;
      end
      return d;
   endfunction

   // Character for a radix-40 digit, letters in lowercase.
   function automatic logic [CharWidth-1:0] radix_char(input logic [CodeWidth-1:0] d);
      logic [CharWidth-1:0] c;
      priority if (d >= 6'd1 && d <= 6'd10) begin
         c = 7'(d) + 7'd47;
      end else if (d >= 6'd11 && d <= 6'd36) begin
         c = 7'(d) + 7'd86;
      end else if (d == 6'd37) begin
         c = 7'h2E;
      end else if (d == 6'd38) begin
         c = 7'h24;
      end else if (d == 6'd39) begin
         c = 7'h25;
      end else begin
         c = 7'(SpaceChar);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ssnc_lane.sv @@
// One character lane: SIXBIT and squoze work for a single character position.
`default_nettype none

module ssnc_lane
   import ssnc_pkg::*;
#(
   parameter int Lane = 0
) (
   input  logic [InCharWidth-1:0] char_in,
   input  logic                   live,
   input  logic [WordWidth-1:0]   word_in,
   output lane_out_type           lane_out
);

   // Digit position counted from the least significant end.
   localparam int Pos   = NumChars - 1 - Lane;
   // This lane finds the squoze value divided by 40 to the power Steps.
   localparam int Steps = Pos + 1;
   // Dividing by 40^n is a shift by 3n followed by a division by 5^n.
   localparam int XW    = SqWidth - 3 * Steps;
   localparam longint unsigned Div = int_pow(5, Steps);
   localparam int DivBits = $clog2(Div);
   localparam int Shift = XW + DivBits;
   localparam int MW    = XW + 1;
   localparam int PW    = Shift + CodeWidth;
   localparam longint unsigned Magic = ((64'd1 << Shift) + Div - 64'd1) / Div;
   localparam logic [SqWidth-1:0] Weight = SqWidth'(int_pow(Radix, Pos));

   logic [MW-1:0]          magic_c;
   logic [InCharWidth-1:0] ch_live;
   logic [InCharWidth-1:0] ch_up;
   logic [CodeWidth-1:0]   digit;
   logic [XW-1:0]          sq_high;
   logic [PW-1:0]          quo_prod;

   assign magic_c = MW'(Magic);

   // SIXBIT encode: an ended name reads as space, lowercase folds to uppercase.
   always_comb begin
      ch_live = live ? char_in : SpaceChar;
      ch_up   = (ch_live >= 8'h61 && ch_live <= 8'h7A) ? ch_live - 8'd32 : ch_live;
   end

   // Squoze encode: this character's digit scaled by its place value.
   assign digit = radix_digit(live ? char_in : NulChar);

   // Reciprocal multiply; only the low bits of the quotient are needed downstream.
   assign sq_high  = word_in[SqWidth-1:3*Steps];
   assign quo_prod = PW'(sq_high) * PW'(magic_c);

   always_comb begin
      lane_out.six_code = ch_up[CodeWidth-1:0] - CodeWidth'(SpaceChar);
      lane_out.sq_term  = SqWidth'(digit) * Weight;
      lane_out.quo_low  = quo_prod[Shift +: CodeWidth];
      lane_out.dec_char = CharWidth'(SpaceChar) + {1'b0, word_in[CodeWidth*Pos +: CodeWidth]};
   end

endmodule

`default_nettype wire

@@ rtl/ssnc_merge.sv @@
// Merge stage: combines the lane results into one result item.
`default_nettype none

module ssnc_merge
   import ssnc_pkg::*;
(
   input  stage_type    stage_in,
   output rsp_item_type rsp_out
);

   logic [WordWidth-1:0] six_word;
   logic [SqWidth-1:0]   sq_sum;
   logic [CodeWidth-1:0] quo_hi [NumChars];
   logic [CodeWidth-1:0] sq_digit [NumChars];
   logic [CharWidth-1:0] chars [NumChars];

   // Pack the SIXBIT codes, first character in the top group.
   always_comb begin
      six_word = '0;
      for (int i = 0; i < NumChars; i++) begin
         six_word = {six_word[WordWidth-CodeWidth-1:0], stage_in.lanes[i].six_code};
      end
   end

   // The squoze value is below 40^6, so the sum never overflows 32 bits.
   always_comb begin
      sq_sum = '0;
      for (int i = 0; i < NumChars; i++) begin
         sq_sum = sq_sum + stage_in.lanes[i].sq_term;
      end
   end

   // Digit i is q_k minus 40 times q_(k+1); the result is below 40, so 6 bits suffice.
   always_comb begin
      for (int i = 0; i < NumChars; i++) begin
         quo_hi[i]   = (i == NumChars - 1) ? stage_in.quo_base : stage_in.lanes[(i + 1) % NumChars].quo_low;
         sq_digit[i] = quo_hi[i] - CodeWidth'(stage_in.lanes[i].quo_low * 6'd40);
      end
   end

   // Select the result of the requested operation.
   always_comb begin
      rsp_out = '0;
      for (int i = 0; i < NumChars; i++) begin
         chars[i] = '0;
      end
      unique case (stage_in.op)
         OP_SIXBIT_ENC: begin
            rsp_out.out_word = six_word;
         end
         OP_SIXBIT_DEC: begin
            for (int i = 0; i < NumChars; i++) begin
               chars[i] = stage_in.lanes[i].dec_char;
            end
         end
         OP_SQUOZE_ENC: begin
            rsp_out.out_word = WordWidth'(sq_sum);
         end
         OP_SQUOZE_DEC: begin
            for (int i = 0; i < NumChars; i++) begin
               chars[i] = radix_char(sq_digit[i]);
            end
         end
         default: begin
            rsp_out.out_word = '0;
         end
      endcase
      rsp_out.out_char_0 = chars[0];
      rsp_out.out_char_1 = chars[1];
      rsp_out.out_char_2 = chars[2];
      rsp_out.out_char_3 = chars[3];
      rsp_out.out_char_4 = chars[4];
      rsp_out.out_char_5 = chars[5];
   end

endmodule

`default_nettype wire

@@ rtl/sixbit_squoze_name_codec_top.sv @@
// Top level of the SIXBIT and squoze name codec: six character lanes and a merge stage.
//
//   Channel   Direction   Handshake               Payload
//   req       in          req_valid / req_ready   req_data  (req_item_type)
//   rsp       out         rsp_valid / rsp_ready   rsp_data  (rsp_item_type)
//
// One item per cycle is accepted and one result per cycle is delivered while the result side is not stalled.
// Each item passes through the lane register, then the result register.
// The lane reciprocal multipliers and the six-way merge add set the clock period.
// Reset clears both valid flags; there is no state beyond the pipeline.
// A stalled result holds the result register; the lane register still takes one more item if it is empty.
`default_nettype none

module sixbit_squoze_name_codec_top
   import ssnc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   logic                   s1_valid_ff, s1_valid_in;
   stage_type              s1_ff, s1_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_item_type           rsp_ff, rsp_in;
   logic                   out_move;
   logic                   s1_take;
   logic [InCharWidth-1:0] chars [NumChars];
   logic [NumChars-1:0]    live;
   lane_out_type           lane_res [NumChars];
   stage_type              s1_new;
   rsp_item_type           merged;

   // Each register loads when it is empty or its content moves on in the same cycle.
   assign out_move  = !rsp_valid_ff || rsp_ready;
   assign s1_take   = !s1_valid_ff || out_move;
   assign req_ready = s1_take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign chars[0] = req_data.in_char_0;
   assign chars[1] = req_data.in_char_1;
   assign chars[2] = req_data.in_char_2;
   assign chars[3] = req_data.in_char_3;
   assign chars[4] = req_data.in_char_4;
   assign chars[5] = req_data.in_char_5;

   // A NUL ends the name: it and every later character are dead.
   always_comb begin
      live[0] = (chars[0] != NulChar);
      for (int i = 1; i < NumChars; i++) begin
         live[i] = live[i-1] && (chars[i] != NulChar);
      end
   end

   // Character lanes.
   for (genvar g = 0; g < NumChars; g++) begin : g_lane
      ssnc_lane #(
         .Lane (g)
      ) u_lane (
         .char_in  (chars[g]),
         .live     (live[g]),
         .word_in  (req_data.in_word),
         .lane_out (lane_res[g])
      );
   end

   always_comb begin
      s1_new.op       = req_data.req_type;
      s1_new.quo_base = req_data.in_word[CodeWidth-1:0];
      for (int i = 0; i < NumChars; i++) begin
         s1_new.lanes[i] = lane_res[i];
      end
   end

   // Merge stage.
   ssnc_merge u_merge (
      .stage_in (s1_ff),
      .rsp_out  (merged)
   );

   // Next values of the two pipeline registers.
   always_comb begin
      s1_valid_in  = s1_take ? req_valid : s1_valid_ff;
      s1_in        = s1_take ? s1_new : s1_ff;
      rsp_valid_in = out_move ? s1_valid_ff : rsp_valid_ff;
      rsp_in       = out_move ? merged : rsp_ff;
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

@@ rtl/ssnc_checker.sv @@
// Port-level checker for the name codec, bound to its top level.
`default_nettype none
`include "sixbit_squoze_name_codec_top_assert.svh"

module ssnc_checker
   import ssnc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_data
);

   // No result is pending right after reset.
   `SSNC_ASSERT_NXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // With the result register empty, the input side must be open.
   `SSNC_ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "input stalled while result register empty")

   // A stalled result keeps its value.
   `SSNC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // A result appears only after an input transfer has passed the lane register and then the result register.
   `SSNC_ASSERT_IMP(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without matching input transfer")

endmodule

bind sixbit_squoze_name_codec_top ssnc_checker u_ssnc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
